>>> rtl/aetp_pkg.sv
// shared types, codes and the colour palette of the escape parser
package aetp_pkg;

    localparam int ACTION_W = 2;
    localparam int CMD_W    = 3;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_CHAR = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FG   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_BG   = 2'd2;

    // display command codes
    localparam logic [CMD_W-1:0] CMD_NONE      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_GLYPH     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_NEWLINE   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RETURN    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_BACKSPACE = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd5;

    // byte codes
    localparam logic [7:0] BYTE_NUL   = 8'h00;
    localparam logic [7:0] BYTE_BS    = 8'h08;
    localparam logic [7:0] BYTE_LF    = 8'h0A;
    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] BYTE_ESC   = 8'h1B;
    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] BYTE_ZERO  = 8'h30;
    localparam logic [7:0] BYTE_NINE  = 8'h39;
    localparam logic [7:0] BYTE_SEMI  = 8'h3B;
    localparam logic [7:0] BYTE_AT    = 8'h40;
    localparam logic [7:0] BYTE_J     = 8'h4A;
    localparam logic [7:0] BYTE_M     = 8'h6D;

    // sgr argument values
    localparam logic [15:0] SGR_FG      = 16'd38;
    localparam logic [15:0] SGR_BG      = 16'd48;
    localparam logic [15:0] SGR_INDEXED = 16'd5;
    localparam logic [15:0] SGR_RGB     = 16'd2;
    localparam logic [15:0] ED_ALL      = 16'd2;
    localparam logic [15:0] ARG_MAX     = 16'hFFFF;

    localparam logic [31:0] FG_RESET = 32'hFFFFFFFF;
    localparam logic [31:0] BG_RESET = 32'h00000000;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PW    = $clog2(FIFO_DEPTH);

    // palette: 6x6x6 cube followed by 24 grey steps
    localparam int PALETTE_SIZE = 240;
    localparam int CUBE_SIZE    = 216;
    localparam logic [7:0] PALETTE_LAST = 8'(PALETTE_SIZE - 1);

    typedef logic [23:0] palette_t [PALETTE_SIZE];
    typedef logic [7:0]  cube_t [6];

    localparam cube_t CUBE_LEVEL = '{8'h00, 8'h5f, 8'h87, 8'haf, 8'hd7, 8'hff};

    function automatic palette_t build_palette();
        palette_t p;
        int k;
        logic [7:0] v;
        k = 0;
        for (int r = 0; r < 6; r++) begin
            for (int g = 0; g < 6; g++) begin
                for (int b = 0; b < 6; b++) begin
                    p[k] = {CUBE_LEVEL[r], CUBE_LEVEL[g], CUBE_LEVEL[b]};
                    k++;
                end
            end
        end
        for (int i = 0; i < PALETTE_SIZE - CUBE_SIZE; i++) begin
            v = 8'(8 + 10 * i);
            p[CUBE_SIZE + i] = {v, v, v};
        end
        return p;
    endfunction

    localparam palette_t PALETTE = build_palette();

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [7:0]          char_byte;
        logic [31:0]         colour_value;
    } item_t;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [7:0]       glyph_code;
        logic [31:0]      fg_colour;
        logic [31:0]      bg_colour;
        logic             last_of_run;
    } result_t;

    // one decoded command from the front, repeated by the back
    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [7:0]       glyph_code;
        logic [31:0]      fg_colour;
        logic [31:0]      bg_colour;
    } job_t;

endpackage

>>> rtl/aetp_fifo.sv
// small word queue between the parser front and the result back
module aetp_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int CW = $clog2(aetp_pkg::FIFO_DEPTH + 1);

    logic [WIDTH-1:0]            mem_reg [aetp_pkg::FIFO_DEPTH];
    logic [aetp_pkg::FIFO_PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]               count_reg;

    assign full     = (count_reg == CW'(aetp_pkg::FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> rtl/aetp_front.sv
// parser front: accepts words, tracks escape state and colours, issues jobs
module aetp_front #(
    parameter int MAX_ARGS   = 16,
    parameter int MAX_INSERT = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_wdata,
    input  logic                                accept,
    input  aetp_pkg::item_t                     item,
    output aetp_pkg::job_t                      job,
    output logic [$clog2(MAX_INSERT + 1)-1:0]   job_count
);

    localparam int IW = $clog2(MAX_ARGS);
    localparam int AW = $clog2(MAX_ARGS + 1);
    localparam int NW = $clog2(MAX_INSERT + 1);

    logic        enabled_reg;
    logic        in_escape_reg, in_escape_next;
    logic [1:0]  esc_cnt_reg, esc_cnt_next;
    logic [15:0] args_reg [MAX_ARGS];
    logic [15:0] args_next [MAX_ARGS];
    logic [AW-1:0] arg_idx_reg, arg_idx_next;
    logic [31:0] fg_reg, fg_next;
    logic [31:0] bg_reg, bg_next;

    logic [aetp_pkg::CMD_W-1:0] cmd;
    logic [7:0]  glyph;
    logic [NW-1:0] count;
    logic        idx_room;
    logic [15:0] cur_arg;
    logic [19:0] times_ten;
    logic [31:0] sgr_colour;
    logic        sgr_load;
    logic [7:0]  c;

    assign c        = item.char_byte;
    assign idx_room = (arg_idx_reg < AW'(MAX_ARGS));
    assign cur_arg  = args_reg[arg_idx_reg[IW-1:0]];
    assign times_ten = {1'b0, cur_arg, 3'b000} + {3'b000, cur_arg, 1'b0}
                     + {16'h0, c[3:0] - aetp_pkg::BYTE_ZERO[3:0]};

    // sgr colour selection from the collected arguments
    always_comb
    begin
        sgr_load   = 1'b0;
        sgr_colour = 32'h0;
        if (args_reg[1] == aetp_pkg::SGR_INDEXED)
        begin
            sgr_load   = (args_reg[2] <= {8'h00, aetp_pkg::PALETTE_LAST});
            sgr_colour = {8'h00, aetp_pkg::PALETTE[args_reg[2][7:0]]};
        end
        else if (args_reg[1] == aetp_pkg::SGR_RGB)
        begin
            sgr_load   = 1'b1;
            sgr_colour = {args_reg[2], 16'h0} + {8'h00, args_reg[3], 8'h00}
                       + {16'h0, args_reg[4]};
        end
    end

    always_comb
    begin
        in_escape_next = in_escape_reg;
        esc_cnt_next   = esc_cnt_reg;
        args_next      = args_reg;
        arg_idx_next   = arg_idx_reg;
        fg_next        = fg_reg;
        bg_next        = bg_reg;
        cmd            = aetp_pkg::CMD_NONE;
        glyph          = 8'h00;
        count          = NW'(1);

        if (item.action == aetp_pkg::ACT_FG)
        begin
            fg_next = item.colour_value;
        end
        else if (item.action == aetp_pkg::ACT_BG)
        begin
            bg_next = item.colour_value;
        end
        else if (item.action == aetp_pkg::ACT_CHAR && c != aetp_pkg::BYTE_NUL && enabled_reg)
        begin
            if (in_escape_reg)
            begin
                if (esc_cnt_reg != 2'd3)
                begin
                    esc_cnt_next = esc_cnt_reg + 2'd1;
                end
                // the byte right after ESC is swallowed
                if (esc_cnt_reg != 2'd0)
                begin
                    if (c inside {[aetp_pkg::BYTE_ZERO:aetp_pkg::BYTE_NINE]})
                    begin
                        if (idx_room)
                        begin
                            args_next[arg_idx_reg[IW-1:0]] =
                                (times_ten > 20'(aetp_pkg::ARG_MAX)) ?
                                aetp_pkg::ARG_MAX : times_ten[15:0];
                        end
                    end
                    else if (c == aetp_pkg::BYTE_SEMI)
                    begin
                        if (idx_room)
                        begin
                            arg_idx_next = arg_idx_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        // final byte: act, then leave the escape
                        case (c)
                            aetp_pkg::BYTE_AT:
                            begin
                                if (args_reg[0] != 16'h0)
                                begin
                                    cmd   = aetp_pkg::CMD_GLYPH;
                                    glyph = aetp_pkg::BYTE_SPACE;
                                    count = (args_reg[0] > 16'(MAX_INSERT)) ?
                                            NW'(MAX_INSERT) : args_reg[0][NW-1:0];
                                end
                            end
                            aetp_pkg::BYTE_M:
                            begin
                                if (sgr_load && args_reg[0] == aetp_pkg::SGR_FG)
                                begin
                                    fg_next = sgr_colour;
                                end
                                else if (sgr_load && args_reg[0] == aetp_pkg::SGR_BG)
                                begin
                                    bg_next = sgr_colour;
                                end
                            end
                            aetp_pkg::BYTE_J:
                            begin
                                if (arg_idx_reg == '0 && args_reg[0] == aetp_pkg::ED_ALL)
                                begin
                                    cmd = aetp_pkg::CMD_CLEAR;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                        in_escape_next = 1'b0;
                        esc_cnt_next   = 2'd0;
                        arg_idx_next   = '0;
                        for (int i = 0; i < MAX_ARGS; i++)
                        begin
                            args_next[i] = 16'h0;
                        end
                    end
                end
            end
            else
            begin
                case (c)
                    aetp_pkg::BYTE_LF:  cmd = aetp_pkg::CMD_NEWLINE;
                    aetp_pkg::BYTE_CR:  cmd = aetp_pkg::CMD_RETURN;
                    aetp_pkg::BYTE_ESC: in_escape_next = 1'b1;
                    aetp_pkg::BYTE_BS:  cmd = aetp_pkg::CMD_BACKSPACE;
                    default:
                    begin
                        cmd   = aetp_pkg::CMD_GLYPH;
                        glyph = c;
                    end
                endcase
            end
        end
    end

    assign job.command    = cmd;
    assign job.glyph_code = glyph;
    assign job.fg_colour  = fg_next;
    assign job.bg_colour  = bg_next;
    assign job_count      = count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg   <= 1'b1;
            in_escape_reg <= 1'b0;
            esc_cnt_reg   <= 2'd0;
            arg_idx_reg   <= '0;
            fg_reg        <= aetp_pkg::FG_RESET;
            bg_reg        <= aetp_pkg::BG_RESET;
            for (int i = 0; i < MAX_ARGS; i++)
            begin
                args_reg[i] <= 16'h0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                enabled_reg <= cfg_wdata;
            end
            if (accept)
            begin
                in_escape_reg <= in_escape_next;
                esc_cnt_reg   <= esc_cnt_next;
                arg_idx_reg   <= arg_idx_next;
                fg_reg        <= fg_next;
                bg_reg        <= bg_next;
                args_reg      <= args_next;
            end
        end
    end

endmodule

>>> rtl/aetp_back.sv
// result back: takes queued jobs and drives one result word per cycle while result_stall is low
module aetp_back #(
    parameter int MAX_INSERT = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                job_empty,
    input  aetp_pkg::job_t                      job,
    input  logic [$clog2(MAX_INSERT + 1)-1:0]   job_count,
    output logic                                job_pop,
    output logic                                result_valid,
    input  logic                                result_stall,
    output aetp_pkg::result_t                   result
);

    localparam int NW = $clog2(MAX_INSERT + 1);

    logic              valid_reg, valid_next;
    aetp_pkg::result_t res_reg, res_next;
    logic [NW-1:0]     rem_reg, rem_next;
    logic              taken;

    assign taken   = valid_reg && !result_stall;
    assign job_pop = !job_empty && (!valid_reg || (taken && rem_reg == '0));

    always_comb
    begin
        valid_next = valid_reg;
        res_next   = res_reg;
        rem_next   = rem_reg;
        if (job_pop)
        begin
            valid_next           = 1'b1;
            res_next.command     = job.command;
            res_next.glyph_code  = job.glyph_code;
            res_next.fg_colour   = job.fg_colour;
            res_next.bg_colour   = job.bg_colour;
            res_next.last_of_run = (job_count == NW'(1));
            rem_next             = job_count - NW'(1);
        end
        else if (taken)
        begin
            if (rem_reg != '0)
            begin
                // repeat the same word for the rest of the run
                rem_next             = rem_reg - NW'(1);
                res_next.last_of_run = (rem_reg == NW'(1));
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rem_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rem_reg   <= rem_next;
        end
    end

    assign result_valid = valid_reg;
    assign result       = res_reg;

endmodule

>>> rtl/ansi_escape_terminal_parser.sv
// top level of the terminal escape parser: front, job queue and back
//
// takes one terminal byte or colour write per word and issues display command
// words; an input word is taken every cycle while the four-entry job queue has
// room, and each input word yields one or more result words; the back drives
// one result word per cycle while result_stall is low, so an '@' run of n
// spaces holds the back for n result words and the input stalls once the job
// queue fills behind it; escape arguments, colours and the output enable live
// in the front and are settled in the cycle the input word is taken
module ansi_escape_terminal_parser #(
    parameter int MAX_ARGS   = 16,
    parameter int MAX_INSERT = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    // configuration: output enable
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    // input words
    input  logic              item_valid,
    output logic              item_stall,
    input  aetp_pkg::item_t   item,
    // result words
    output logic              result_valid,
    input  logic              result_stall,
    output aetp_pkg::result_t result
);

    localparam int NW    = $clog2(MAX_INSERT + 1);
    localparam int JOB_W = NW + $bits(aetp_pkg::job_t);

    logic                accept;
    logic                q_full, q_empty, q_pop;
    aetp_pkg::job_t      f_job, b_job;
    logic [NW-1:0]       f_count, b_count;
    logic [JOB_W-1:0]    q_out;

    // input is held off only by a full job queue
    assign item_stall = q_full;
    assign accept     = item_valid && !q_full;

    aetp_front #(
        .MAX_ARGS   (MAX_ARGS),
        .MAX_INSERT (MAX_INSERT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .item      (item),
        .job       (f_job),
        .job_count (f_count)
    );

    // every accepted word leaves exactly one job, with its result count
    aetp_fifo #(
        .WIDTH (JOB_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data ({f_count, f_job}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    assign b_count = q_out[JOB_W-1 -: NW];
    assign b_job   = q_out[$bits(aetp_pkg::job_t)-1:0];

    aetp_back #(
        .MAX_INSERT (MAX_INSERT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_empty    (q_empty),
        .job          (b_job),
        .job_count    (b_count),
        .job_pop      (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

>>> tb/sv/ansi_escape_terminal_parser_tb.sv
// self-checking testbench for the terminal escape parser, with directed and random byte streams
module ansi_escape_terminal_parser_tb;

    // block sizes under test, kept equal to the block's defaults
    localparam int ARG_SLOTS  = 16;
    localparam int INSERT_CAP = 64;

    // the action code the block must ignore
    localparam logic [aetp_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

    // introducer that normally follows ESC; the block just swallows it
    localparam logic [7:0] BYTE_LBRACKET = 8'h5B;

    // marks an argument sent as no digits at all
    localparam int unsigned EMPTY_ARG = 32'hFFFF_FFFF;

    // cycles allowed after the last result before a config write or the end
    localparam int SETTLE_CYCLES = 12;

    // cycles with no word moving on either side before the run is abandoned
    localparam int STALL_LIMIT = 2000;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic              cfg_wdata;
    logic              item_valid;
    logic              item_stall;
    aetp_pkg::item_t   item;
    logic              result_valid;
    logic              result_stall;
    aetp_pkg::result_t result;

    // idling percentages of the current phase
    int unsigned feed_gap_pct;
    int unsigned drain_stall_pct;

    int unsigned errors;
    int unsigned words_sent;
    int unsigned quiet_cycles;

    // results still owed by the block, oldest first
    aetp_pkg::result_t pending_results [$];

    // argument list for the next escape sequence
    int unsigned seq_args [$];

    // predicted block state
    logic        out_enable;
    logic        esc_active;
    logic [1:0]  esc_seen;
    logic [15:0] esc_arg [ARG_SLOTS];
    logic [4:0]  esc_argn;
    logic [31:0] fg_now;
    logic [31:0] bg_now;

    ansi_escape_terminal_parser #(
        .MAX_ARGS   (ARG_SLOTS),
        .MAX_INSERT (INSERT_CAP)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // colour palette: 6x6x6 cube, then 24 grey steps
    // ---------------------------------------------------------------

    function automatic logic [7:0] cube_step(int unsigned lvl);
        case (lvl)
            0: return 8'h00;
            1: return 8'h5f;
            2: return 8'h87;
            3: return 8'haf;
            4: return 8'hd7;
            default: return 8'hff;
        endcase
    endfunction

    function automatic logic [31:0] palette_rgb(int unsigned idx);
        int unsigned grey;
        if (idx < 216)
            return {8'h00, cube_step(idx / 36), cube_step((idx / 6) % 6), cube_step(idx % 6)};
        grey = 8 + 10 * (idx - 216);
        return {8'h00, 8'(grey), 8'(grey), 8'(grey)};
    endfunction

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    task automatic clear_escape();
        esc_active = 1'b0;
        esc_seen   = 2'd0;
        esc_argn   = 5'd0;
        foreach (esc_arg[k])
            esc_arg[k] = 16'd0;
    endtask

    // work out the result words of one accepted input word and queue them
    task automatic predict_word(aetp_pkg::item_t w);
        logic [aetp_pkg::CMD_W-1:0] cmd;
        logic [7:0]                 glyph;
        logic [7:0]                 c;
        logic [31:0]                tone;
        logic                       recolour;
        int unsigned                reps;
        int unsigned                acc;
        aetp_pkg::result_t          r;
        cmd      = aetp_pkg::CMD_NONE;
        glyph    = 8'h00;
        reps     = 1;
        recolour = 1'b0;
        tone     = 32'h0;
        c        = w.char_byte;
        if (w.action == aetp_pkg::ACT_FG)
            fg_now = w.colour_value;
        else if (w.action == aetp_pkg::ACT_BG)
            bg_now = w.colour_value;
        else if (w.action == aetp_pkg::ACT_CHAR && c != aetp_pkg::BYTE_NUL && out_enable)
        begin
            if (esc_active)
            begin
                if (esc_seen != 2'd3)
                    esc_seen = esc_seen + 2'd1;
                if (esc_seen == 2'd1)
                begin
                    // first byte after ESC is swallowed whatever it is
                end
                else if (c inside {[aetp_pkg::BYTE_ZERO:aetp_pkg::BYTE_NINE]})
                begin
                    // digits past the last argument slot are dropped
                    if (esc_argn < ARG_SLOTS)
                    begin
                        acc = 32'(esc_arg[esc_argn]) * 10 + 32'(c - aetp_pkg::BYTE_ZERO);
                        esc_arg[esc_argn] = (acc > 65535) ? aetp_pkg::ARG_MAX : 16'(acc);
                    end
                end
                else if (c == aetp_pkg::BYTE_SEMI)
                begin
                    if (esc_argn < ARG_SLOTS)
                        esc_argn = esc_argn + 5'd1;
                end
                else
                begin
                    // final byte: act on it, then leave the escape
                    if (c == aetp_pkg::BYTE_AT)
                    begin
                        reps = (esc_arg[0] > INSERT_CAP) ? INSERT_CAP : esc_arg[0];
                        if (reps == 0)
                            reps = 1;
                        else
                        begin
                            cmd   = aetp_pkg::CMD_GLYPH;
                            glyph = aetp_pkg::BYTE_SPACE;
                        end
                    end
                    else if (c == aetp_pkg::BYTE_M &&
                             (esc_arg[0] == aetp_pkg::SGR_FG || esc_arg[0] == aetp_pkg::SGR_BG))
                    begin
                        if (esc_arg[1] == aetp_pkg::SGR_INDEXED &&
                            esc_arg[2] <= aetp_pkg::PALETTE_LAST)
                        begin
                            tone     = palette_rgb(esc_arg[2]);
                            recolour = 1'b1;
                        end
                        else if (esc_arg[1] == aetp_pkg::SGR_RGB)
                        begin
                            tone = (32'(esc_arg[2]) << 16) + (32'(esc_arg[3]) << 8)
                                 + 32'(esc_arg[4]);
                            recolour = 1'b1;
                        end
                        if (recolour)
                        begin
                            if (esc_arg[0] == aetp_pkg::SGR_FG)
                                fg_now = tone;
                            else
                                bg_now = tone;
                        end
                    end
                    else if (c == aetp_pkg::BYTE_J && esc_argn == 5'd0 &&
                             esc_arg[0] == aetp_pkg::ED_ALL)
                        cmd = aetp_pkg::CMD_CLEAR;
                    clear_escape();
                end
            end
            else if (c == aetp_pkg::BYTE_LF)
                cmd = aetp_pkg::CMD_NEWLINE;
            else if (c == aetp_pkg::BYTE_CR)
                cmd = aetp_pkg::CMD_RETURN;
            else if (c == aetp_pkg::BYTE_ESC)
                esc_active = 1'b1;
            else if (c == aetp_pkg::BYTE_BS)
                cmd = aetp_pkg::CMD_BACKSPACE;
            else
            begin
                cmd   = aetp_pkg::CMD_GLYPH;
                glyph = c;
            end
        end
        for (int k = 0; k < reps; k++)
        begin
            r.command     = cmd;
            r.glyph_code  = glyph;
            r.fg_colour   = fg_now;
            r.bg_colour   = bg_now;
            r.last_of_run = (k == reps - 1);
            pending_results.push_back(r);
        end
    endtask

    // ---------------------------------------------------------------
    // input side: called at a falling edge, returns at a falling edge;
    // valid stays high afterwards so back-to-back words need no gap
    // ---------------------------------------------------------------

    task automatic send_word(aetp_pkg::item_t w);
        while ($urandom_range(99) < feed_gap_pct)
        begin
            item_valid = 1'b0;
            @(negedge clk);
        end
        item       = w;
        item_valid = 1'b1;
        // flop outputs still hold their pre-edge value here
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        predict_word(w);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic send_char(logic [7:0] c);
        aetp_pkg::item_t w;
        w.action       = aetp_pkg::ACT_CHAR;
        w.char_byte    = c;
        w.colour_value = $urandom();
        send_word(w);
    endtask

    task automatic send_colour(logic [aetp_pkg::ACTION_W-1:0] act, logic [31:0] colour);
        aetp_pkg::item_t w;
        w.action       = act;
        w.char_byte    = 8'($urandom_range(255));
        w.colour_value = colour;
        send_word(w);
    endtask

    // ESC, introducer, seq_args as decimal separated by ';', final byte;
    // nul_pct sprinkles ignored zero bytes inside the sequence
    task automatic send_escape(logic [7:0] intro, logic [7:0] fin, int unsigned nul_pct);
        logic [7:0]  seq [$];
        logic [7:0]  digits [$];
        int unsigned v;
        seq.delete();
        seq.push_back(intro);
        foreach (seq_args[i])
        begin
            if (i != 0)
                seq.push_back(aetp_pkg::BYTE_SEMI);
            if (seq_args[i] != EMPTY_ARG)
            begin
                v = seq_args[i];
                digits.delete();
                do
                begin
                    digits.push_front(8'(aetp_pkg::BYTE_ZERO + v % 10));
                    v = v / 10;
                end
                while (v != 0);
                foreach (digits[k])
                    seq.push_back(digits[k]);
            end
        end
        seq.push_back(fin);
        send_char(aetp_pkg::BYTE_ESC);
        foreach (seq[k])
        begin
            if ($urandom_range(99) < nul_pct)
                send_char(aetp_pkg::BYTE_NUL);
            send_char(seq[k]);
        end
    endtask

    // drop valid and let every owed result come out, plus a margin
    task automatic wait_drained();
        item_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_output_enable(logic en);
        wait_drained();
        cfg_we     = 1'b1;
        cfg_wdata  = en;
        @(negedge clk);
        cfg_we     = 1'b0;
        out_enable = en;
    endtask

    task automatic set_idling(int unsigned gap_pct, int unsigned stall_pct);
        feed_gap_pct    = gap_pct;
        drain_stall_pct = stall_pct;
    endtask

    // ---------------------------------------------------------------
    // output side: receiver stall and result checking
    // ---------------------------------------------------------------

    always @(negedge clk)
        result_stall = ($urandom_range(99) < drain_stall_pct);

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : check_results
        aetp_pkg::result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with nothing expected: command %0d glyph %0h",
                       result.command, result.glyph_code);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("command", want.command, result.command);
                check_field("glyph_code", want.glyph_code, result.glyph_code);
                check_field("fg_colour", want.fg_colour, result.fg_colour);
                check_field("bg_colour", want.bg_colour, result.bg_colour);
                check_field("last_of_run", want.last_of_run, result.last_of_run);
            end
        end
    end

    // watchdog: nothing moving on either side for too long means a hang
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("ansi_escape_terminal_parser_tb: FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // zero byte, unused action, the three controls and glyph extremes
    task automatic test_plain_bytes();
        send_char(aetp_pkg::BYTE_NUL);
        send_colour(ACT_UNUSED, 32'hFFFF_FFFF);
        send_char(aetp_pkg::BYTE_LF);
        send_char(aetp_pkg::BYTE_CR);
        send_char(aetp_pkg::BYTE_BS);
        send_char(8'hFF);
        send_char(8'h01);
        send_char(8'h7F);
    endtask

    // direct colour writes at both extremes, then a glyph to show them
    task automatic test_colour_writes();
        send_colour(aetp_pkg::ACT_FG, 32'h0000_0000);
        send_colour(aetp_pkg::ACT_BG, 32'hFFFF_FFFF);
        send_char(8'h41);
        send_colour(aetp_pkg::ACT_FG, 32'hFFFF_FFFF);
        send_colour(aetp_pkg::ACT_BG, 32'h0000_0000);
    endtask

    task automatic test_escapes();
        // argument overflow saturates, then the insert is capped
        seq_args = {32'd99999};
        send_escape(BYTE_LBRACKET, aetp_pkg::BYTE_AT, 0);
        seq_args = {32'd3};
        send_escape(BYTE_LBRACKET, aetp_pkg::BYTE_AT, 0);
        // empty insert gives one idle word
        seq_args.delete();
        send_escape(BYTE_LBRACKET, aetp_pkg::BYTE_AT, 0);
        // clear only with exactly one argument equal to 2
        seq_args = {32'd2};
        send_escape(BYTE_LBRACKET, aetp_pkg::BYTE_J, 0);
        seq_args = {32'd2, 32'd2};
        send_escape(BYTE_LBRACKET, aetp_pkg::BYTE_J, 0);
        // palette index out of range, last grey, then rgb with carry
        seq_args = {32'd38, 32'd5, 32'd240};
        send_escape(BYTE_LBRACKET, aetp_pkg::BYTE_M, 0);
        seq_args = {32'd38, 32'd5, 32'd239};
        send_escape(BYTE_LBRACKET, aetp_pkg::BYTE_M, 0);
        seq_args = {32'd48, 32'd2, 32'd65535, 32'd255, 32'd300};
        send_escape(BYTE_LBRACKET, aetp_pkg::BYTE_M, 0);
        // control byte inside an escape just ends it
        send_char(aetp_pkg::BYTE_ESC);
        send_char(BYTE_LBRACKET);
        send_char(aetp_pkg::BYTE_LF);
        send_char(8'h78);
        // swallowed digit after ESC, zero byte skipped mid-sequence
        send_char(aetp_pkg::BYTE_ESC);
        send_char(8'h37);
        send_char(8'h32);
        send_char(aetp_pkg::BYTE_NUL);
        send_char(aetp_pkg::BYTE_AT);
        // argument list overflows its slots: the late digit is dropped
        seq_args.delete();
        repeat (ARG_SLOTS + 2) seq_args.push_back(EMPTY_ARG);
        seq_args.push_back(32'd7);
        send_escape(BYTE_LBRACKET, aetp_pkg::BYTE_J, 0);
    endtask

    // with output off, bytes are ignored but colour writes still land
    task automatic test_output_enable();
        set_output_enable(1'b0);
        send_char(aetp_pkg::BYTE_ESC);
        send_char(BYTE_LBRACKET);
        send_char(8'h35);
        send_char(aetp_pkg::BYTE_AT);
        send_char(aetp_pkg::BYTE_LF);
        send_colour(aetp_pkg::ACT_FG, $urandom());
        send_colour(aetp_pkg::ACT_BG, $urandom());
        set_output_enable(1'b1);
        // no escape was opened, so the bracket draws
        send_char(BYTE_LBRACKET);
    endtask

    // one escape sequence, mostly well formed with random content
    task automatic send_random_escape();
        int unsigned pick;
        int unsigned nargs;
        logic [7:0]  intro;
        logic [7:0]  fin;
        seq_args.delete();
        intro = ($urandom_range(9) < 9) ? BYTE_LBRACKET : 8'($urandom_range(255));
        pick  = $urandom_range(99);
        if (pick < 35)
        begin
            fin = aetp_pkg::BYTE_M;
            seq_args.push_back(($urandom_range(9) < 8) ? ($urandom_range(1) ? 38 : 48)
                                                       : $urandom_range(99));
            if ($urandom_range(1))
            begin
                seq_args.push_back(($urandom_range(9) < 9) ? 32'(aetp_pkg::SGR_INDEXED)
                                                           : $urandom_range(9));
                seq_args.push_back(($urandom_range(9) < 8) ? $urandom_range(239)
                                                           : $urandom_range(240, 99999));
            end
            else
            begin
                seq_args.push_back(32'(aetp_pkg::SGR_RGB));
                repeat (3)
                    seq_args.push_back(($urandom_range(9) < 8) ? $urandom_range(255)
                                                               : $urandom_range(99999));
            end
        end
        else if (pick < 60)
        begin
            // mostly short inserts; long ones only now and then
            fin = aetp_pkg::BYTE_AT;
            case ($urandom_range(19))
                0: seq_args.push_back(0);
                1: seq_args.push_back($urandom_range(60, 70));
                2: seq_args.push_back($urandom_range(65000, 99999));
                3: ;
                default: seq_args.push_back($urandom_range(1, 6));
            endcase
        end
        else if (pick < 75)
        begin
            fin = aetp_pkg::BYTE_J;
            seq_args.push_back(($urandom_range(9) < 7) ? 2 : $urandom_range(9));
            if ($urandom_range(3) == 0)
                seq_args.push_back($urandom_range(9));
        end
        else
        begin
            // anything goes, including argument lists past the slot count
            fin   = 8'($urandom_range(255));
            nargs = $urandom_range(ARG_SLOTS + 4);
            repeat (nargs)
            begin
                if ($urandom_range(9) == 0)
                    seq_args.push_back(EMPTY_ARG);
                else if ($urandom_range(9) < 2)
                    seq_args.push_back($urandom_range(60000, 999999));
                else
                    seq_args.push_back($urandom_range(300));
            end
        end
        send_escape(intro, fin, 3);
    endtask

    task automatic test_random(int unsigned words);
        int unsigned first;
        int unsigned pick;
        set_output_enable(1'b1);
        first = words_sent;
        while (words_sent - first < words)
        begin
            pick = $urandom_range(99);
            if (pick < 15)
                send_char(8'($urandom_range(32, 126)));
            else if (pick < 22)
            begin
                case ($urandom_range(2))
                    0: send_char(aetp_pkg::BYTE_LF);
                    1: send_char(aetp_pkg::BYTE_CR);
                    default: send_char(aetp_pkg::BYTE_BS);
                endcase
            end
            else if (pick < 30)
                send_char(8'($urandom_range(255)));
            else if (pick < 38)
            begin
                case ($urandom_range(4))
                    0: send_colour(ACT_UNUSED, $urandom());
                    1, 2: send_colour(aetp_pkg::ACT_FG, $urandom());
                    default: send_colour(aetp_pkg::ACT_BG, $urandom());
                endcase
            end
            else
                send_random_escape();
        end
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        result_stall = 1'b0;
        errors       = 0;
        words_sent   = 0;
        quiet_cycles = 0;
        out_enable   = 1'b1;
        fg_now       = aetp_pkg::FG_RESET;
        bg_now       = aetp_pkg::BG_RESET;
        clear_escape();
        set_idling(0, 0);
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_plain_bytes();
        test_colour_writes();
        test_escapes();
        test_output_enable();

        // random words under each idling pattern
        set_idling(0, 0);
        test_random(30);
        set_idling(74, 0);
        test_random(30);
        set_idling(0, 74);
        test_random(30);
        set_idling(11, 11);
        test_random(30);

        // every owed result in, then a quiet tail to catch strays
        set_idling(0, 0);
        wait_drained();

        if (errors == 0)
            $display("ansi_escape_terminal_parser_tb: PASS");
        else
            $display("ansi_escape_terminal_parser_tb: FAIL");
        $finish;
    end

endmodule
